// ----- src/osaed_pkg.sv -----
// Shared types, constants and helpers for the bit-parallel OSA edit-distance column.
// No dependencies; used by bitvector_osa_edit_distance_column.
package osaed_pkg;

  // column size and field widths
  localparam int QUERY_BITS_DEFAULT = 64;
  localparam int MATCH_W            = 64;
  localparam int QLEN_W             = 7;
  localparam int MAXD_W             = 8;
  localparam int DIST_W             = 16;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_QUERY_LENGTH   = 1'b0;
  localparam logic REG_DISTANCE_LIMIT = 1'b1;

  // row scan: running sum and lowest prefix of a run of rows, signed
  localparam int SCAN_W = 8;

  typedef struct packed {
    logic signed [SCAN_W-1:0] total;
    logic signed [SCAN_W-1:0] low;
  } scan_node_t;

  // one row: +1 delta lowers the value going down, -1 delta raises it
  function automatic scan_node_t scan_leaf(input logic plus, input logic minus);
    scan_node_t node;
    if (plus) begin
      node.total = -SCAN_W'(1);
      node.low   = -SCAN_W'(1);
    end else if (minus) begin
      node.total = SCAN_W'(1);
      node.low   = '0;
    end else begin
      node.total = '0;
      node.low   = '0;
    end
    return node;
  endfunction

  // join two runs: hi_seg is scanned first (higher rows)
  function automatic scan_node_t scan_join(input scan_node_t hi_seg, input scan_node_t lo_seg);
    scan_node_t node;
    logic signed [SCAN_W-1:0] cand;
    cand       = hi_seg.total + lo_seg.low;
    node.total = hi_seg.total + lo_seg.total;
    node.low   = (cand < hi_seg.low) ? cand : hi_seg.low;
    return node;
  endfunction

endpackage

// ----- src/bitvector_osa_edit_distance_column.sv -----
// Bit-parallel restricted Damerau-Levenshtein (OSA) column, one target character per beat.
// Depends on osaed_pkg (types, widths, row-scan helpers).
//
// Usage:
//   Input channel (in_valid/in_ready) carries match_mask, the query positions equal to
//   the target character, and restart, which steps from the initial column instead of
//   the stored one. Output channel (out_valid/out_ready) carries distance, the edit
//   distance of the whole query so far (saturating), within_threshold and
//   may_still_match (some row of the column is at most distance_limit).
//   query_length and distance_limit are written through the APB-style port at byte
//   addresses 0 and 4; write them only while no beat is in flight.
//   Pipeline: input register, column update, two registered stages of the row-scan
//   prefix tree, and the output register. Throughput: one beat per cycle while the
//   output is not stalled, set by the combinational column update feeding the next
//   beat through the state registers.
//   Reset clears the registers, the column state and all pipeline valids.
//   When the receiver stalls, beats fill the empty pipeline stages; in_ready drops
//   only when all five stages hold a beat.
module bitvector_osa_edit_distance_column #(
  parameter int QUERY_BITS = osaed_pkg::QUERY_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // input beats
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [osaed_pkg::MATCH_W-1:0]      match_mask,
  input  logic                               restart,
  // result beats
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [osaed_pkg::DIST_W-1:0]       distance,
  output logic                               within_threshold,
  output logic                               may_still_match,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [osaed_pkg::ADDR_W-1:0]       paddr,
  input  logic [osaed_pkg::DATA_W-1:0]       pwdata,
  output logic [osaed_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int QB     = QUERY_BITS;
  localparam int LEVELS = $clog2(QUERY_BITS);
  localparam int LEAVES = 1 << LEVELS;
  localparam int QLEN_W = osaed_pkg::QLEN_W;
  localparam int MAXD_W = osaed_pkg::MAXD_W;
  localparam int DIST_W = osaed_pkg::DIST_W;
  localparam int SCAN_W = osaed_pkg::SCAN_W;
  localparam int CMP_W  = DIST_W + 2;
  localparam logic [QLEN_W-1:0] QB_LEN = QLEN_W'(QUERY_BITS);

  // configuration registers
  logic [QLEN_W-1:0] query_length;
  logic [MAXD_W-1:0] distance_limit;

  // column state
  logic [QB-1:0]     vertical_plus;
  logic [QB-1:0]     vertical_minus;
  logic [QB-1:0]     previous_match_mask;
  logic [QB-1:0]     previous_diagonal_zero;
  logic [DIST_W-1:0] running_distance;

  // pipeline registers
  logic              s0_valid;
  logic [QB-1:0]     s0_mask;
  logic              s0_restart;
  logic              s1_valid;
  logic [LEAVES-1:0] s1_vp;
  logic [LEAVES-1:0] s1_vn;
  logic [DIST_W-1:0] s1_dist;
  logic              s2_valid;
  osaed_pkg::scan_node_t s2_node [LEAVES];
  logic [DIST_W-1:0] s2_dist;
  logic              s3_valid;
  osaed_pkg::scan_node_t s3_node [LEAVES];
  logic [DIST_W-1:0] s3_dist;

  // stage flow control
  logic s0_go, s1_free, s2_free, s3_free, out_free;

  // column update signals
  logic [QLEN_W-1:0] eff_len;
  logic [QB-1:0]     row_mask, top_mask;
  logic [QB-1:0]     pm, vp, vn, pmp, d0p;
  logic [QB-1:0]     tc, d0, hp, hn, hp_sh, hn_sh;
  logic [DIST_W-1:0] dist_in;
  logic [QB-1:0]     vp_next, vn_next, pm_next, d0_next;
  logic [DIST_W-1:0] dist_next;

  // scan tree signals
  osaed_pkg::scan_node_t tree_a [LEAVES];
  osaed_pkg::scan_node_t tree_b [LEAVES];
  osaed_pkg::scan_node_t tree_c [LEAVES];
  logic signed [CMP_W-1:0] low_row;
  logic signed [CMP_W-1:0] limit;

  // handshake chain, each stage loads when empty or when it drains
  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = !s0_valid || s1_free;
  assign s0_go    = s0_valid && s1_free;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length   <= '0;
      distance_limit <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[osaed_pkg::REG_SEL_BIT])
        osaed_pkg::REG_QUERY_LENGTH:   query_length   <= pwdata[QLEN_W-1:0];
        osaed_pkg::REG_DISTANCE_LIMIT: distance_limit <= pwdata[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[osaed_pkg::REG_SEL_BIT])
      osaed_pkg::REG_QUERY_LENGTH:   prdata = osaed_pkg::DATA_W'(query_length);
      osaed_pkg::REG_DISTANCE_LIMIT: prdata = osaed_pkg::DATA_W'(distance_limit);
      default:                       prdata = '0;
    endcase
  end

  // row mask and its top row
  always_comb begin
    eff_len = (query_length > QB_LEN) ? QB_LEN : query_length;
    for (int i = 0; i < QB; i++) begin
      row_mask[i] = (QLEN_W'(i) < eff_len);
    end
    top_mask = row_mask & ~(row_mask >> 1);
  end

  // column update from the input register and the stored column
  always_comb begin
    pm = s0_mask & row_mask;
    if (s0_restart) begin
      vp      = row_mask;
      vn      = '0;
      pmp     = '0;
      d0p     = '0;
      dist_in = DIST_W'(eff_len);
    end else begin
      vp      = vertical_plus & row_mask;
      vn      = vertical_minus & row_mask;
      pmp     = previous_match_mask & row_mask;
      d0p     = previous_diagonal_zero & row_mask;
      dist_in = running_distance;
    end

    tc    = ((~d0p & pm) << 1) & pmp;
    d0    = ((((pm & vp) + vp) ^ vp) | pm | vn | tc) & row_mask;
    hp    = vn | ~(d0 | vp);
    hn    = vp & d0;
    hp_sh = (hp << 1) | QB'(1);
    hn_sh = hn << 1;

    if (eff_len == '0) begin
      vp_next   = '0;
      vn_next   = '0;
      pm_next   = '0;
      d0_next   = '0;
      dist_next = (dist_in == osaed_pkg::DIST_MAX) ? dist_in : dist_in + DIST_W'(1);
    end else begin
      vp_next = (hn_sh | ~(d0 | hp_sh)) & row_mask;
      vn_next = hp_sh & d0 & row_mask;
      pm_next = pm;
      d0_next = d0;
      if (|(hp & top_mask)) begin
        dist_next = (dist_in == osaed_pkg::DIST_MAX) ? dist_in : dist_in + DIST_W'(1);
      end else if (|(hn & top_mask)) begin
        dist_next = (dist_in == '0) ? dist_in : dist_in - DIST_W'(1);
      end else begin
        dist_next = dist_in;
      end
    end
  end

  // column state advances as each beat leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_plus          <= '0;
      vertical_minus         <= '0;
      previous_match_mask    <= '0;
      previous_diagonal_zero <= '0;
      running_distance       <= '0;
    end else if (s0_go) begin
      vertical_plus          <= vp_next;
      vertical_minus         <= vn_next;
      previous_match_mask    <= pm_next;
      previous_diagonal_zero <= d0_next;
      running_distance       <= dist_next;
    end
  end

  // scan tree, first two levels from the row deltas
  always_comb begin
    for (int j = 0; j < LEAVES; j++) begin
      tree_a[j] = osaed_pkg::scan_leaf(s1_vp[j], s1_vn[j]);
    end
    for (int l = 0; l < 2; l++) begin
      if (l < LEVELS) begin
        for (int j = 0; j < LEAVES / 2; j++) begin
          tree_a[j] = osaed_pkg::scan_join(tree_a[2*j+1], tree_a[2*j]);
        end
      end
    end
  end

  // scan tree, levels two and three
  always_comb begin
    for (int j = 0; j < LEAVES; j++) begin
      tree_b[j] = s2_node[j];
    end
    for (int l = 2; l < 4; l++) begin
      if (l < LEVELS) begin
        for (int j = 0; j < LEAVES / 2; j++) begin
          tree_b[j] = osaed_pkg::scan_join(tree_b[2*j+1], tree_b[2*j]);
        end
      end
    end
  end

  // scan tree, levels four and five, then the lowest row against the threshold
  always_comb begin
    for (int j = 0; j < LEAVES; j++) begin
      tree_c[j] = s3_node[j];
    end
    for (int l = 4; l < 6; l++) begin
      if (l < LEVELS) begin
        for (int j = 0; j < LEAVES / 2; j++) begin
          tree_c[j] = osaed_pkg::scan_join(tree_c[2*j+1], tree_c[2*j]);
        end
      end
    end
    low_row = $signed({2'b00, s3_dist})
            + $signed({{(CMP_W-SCAN_W){tree_c[0].low[SCAN_W-1]}}, tree_c[0].low});
    limit   = $signed({{(CMP_W-MAXD_W){1'b0}}, distance_limit});
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s0_valid  <= in_valid;
      if (s1_free)  s1_valid  <= s0_valid;
      if (s2_free)  s2_valid  <= s1_valid;
      if (s3_free)  s3_valid  <= s2_valid;
      if (out_free) out_valid <= s3_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_mask    <= match_mask[QB-1:0];
      s0_restart <= restart;
    end
    if (s0_go) begin
      s1_vp   <= LEAVES'(vp_next);
      s1_vn   <= LEAVES'(vn_next);
      s1_dist <= dist_next;
    end
    if (s2_free && s1_valid) begin
      s2_node <= tree_a;
      s2_dist <= s1_dist;
    end
    if (s3_free && s2_valid) begin
      s3_node <= tree_b;
      s3_dist <= s2_dist;
    end
    if (out_free && s3_valid) begin
      distance         <= s3_dist;
      within_threshold <= (s3_dist <= DIST_W'(distance_limit));
      may_still_match  <= (low_row <= limit);
    end
  end

endmodule
